@@ hdl/table_newton_float_sqrt_defines.svh @@
// Assertion macros shared by the square root block
`ifndef TABLE_NEWTON_FLOAT_SQRT_DEFINES_SVH
`define TABLE_NEWTON_FLOAT_SQRT_DEFINES_SVH

// Check cons in the same cycle as ante
`define TNFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante
`define TNFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tnfs_pkg.sv @@
// Shared constants and types of the table-seeded Newton square root block
package tnfs_pkg;

   localparam int EXP_TABLE_DEPTH  = 256;
   localparam int MANT_TABLE_DEPTH = 1024;
   localparam int QUEUE_DEPTH      = 4;

   // Stage counts of the arithmetic units
   localparam int FMUL_LAT = 3;
   localparam int FADD_LAT = 3;

   localparam logic [31:0] F32_HALF   = 32'h3F00_0000;
   localparam logic [31:0] F32_ONE_P5 = 32'h3FC0_0000;
   localparam logic [31:0] F32_QNAN   = 32'h7FC0_0000;

   typedef logic [31:0] word_type;

   // One classified sample, as it travels from front to back
   typedef struct packed {
      logic [31:0] sample;
      logic [31:0] exp_scale;
      logic [31:0] mant_scale;
      logic        neg;
      logic        last;
   } item_type;

   typedef struct packed {
      logic [31:0] root;
      logic        done;
   } result_type;

endpackage

@@ hdl/tnfs_fmul.sv @@
// Pipelined binary32 multiplier, round to nearest even, subnormals kept
module tnfs_fmul (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import tnfs_pkg::*;

   // stage 1: classify, add exponents, multiply significands
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [7:0]  ea_eff, eb_eff;
   logic [23:0] sig_a, sig_b;
   logic        sign_in, nan_in, inf_in;
   logic [9:0]  esum_in;
   logic [47:0] prod_in;

   logic        sign_s1_ff, nan_s1_ff, inf_s1_ff;
   logic [9:0]  esum_s1_ff;
   logic [47:0] prod_s1_ff;

   always_comb begin
      a_nan   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      a_zero  = (a[30:0] == 31'd0);
      b_zero  = (b[30:0] == 31'd0);
      ea_eff  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb_eff  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      sig_a   = {(a[30:23] != 8'd0), a[22:0]};
      sig_b   = {(b[30:23] != 8'd0), b[22:0]};
      sign_in = a[31] ^ b[31];
      nan_in  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      inf_in  = !nan_in && (a_inf || b_inf);
      esum_in = {2'b00, ea_eff} + {2'b00, eb_eff};
      prod_in = {24'd0, sig_a} * {24'd0, sig_b};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sign_s1_ff <= sign_in;
         nan_s1_ff  <= nan_in;
         inf_s1_ff  <= inf_in;
         esum_s1_ff <= esum_in;
         prod_s1_ff <= prod_in;
      end
   end

   // stage 2: leading zero count and shift plan
   logic [5:0]         lz;
   logic signed [10:0] exp_e, sub_gap, rest;
   logic [5:0]         lsh_in, rsh_in;
   logic [8:0]         ebase_in;

   logic        sign_s2_ff, nan_s2_ff, inf_s2_ff, zero_s2_ff;
   logic [47:0] prod_s2_ff;
   logic [5:0]  lsh_s2_ff, rsh_s2_ff;
   logic [8:0]  ebase_s2_ff;

   always_comb begin
      lz = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (prod_s1_ff[i]) lz = 6'(47 - i);
      end
      exp_e    = $signed({1'b0, esum_s1_ff}) - 11'sd126 - $signed({5'b0, lz});
      sub_gap  = 11'sd1 - exp_e;
      rest     = $signed({5'b0, lz}) - sub_gap;
      lsh_in   = 6'd0;
      rsh_in   = 6'd0;
      ebase_in = 9'd0;
      if (exp_e > 11'sd0) begin
         lsh_in   = lz;
         ebase_in = 9'(exp_e - 11'sd1);
      end else if (rest >= 11'sd0) begin
         lsh_in = rest[5:0];
      end else if (-rest > 11'sd63) begin
         rsh_in = 6'd63;
      end else begin
         rsh_in = 6'(-rest);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sign_s2_ff  <= sign_s1_ff;
         nan_s2_ff   <= nan_s1_ff;
         inf_s2_ff   <= inf_s1_ff;
         zero_s2_ff  <= (prod_s1_ff == 48'd0);
         prod_s2_ff  <= prod_s1_ff;
         lsh_s2_ff   <= lsh_in;
         rsh_s2_ff   <= rsh_in;
         ebase_s2_ff <= ebase_in;
      end
   end

   // stage 3: align, round, pack
   logic [47:0] q;
   logic        rsticky, grd, stk, inc;
   logic [23:0] rnd;
   logic [32:0] total;
   logic [31:0] y_in;
   logic [31:0] y_ff;

   always_comb begin
      if (rsh_s2_ff != 6'd0) begin
         q       = prod_s2_ff >> rsh_s2_ff;
         rsticky = |(prod_s2_ff & ~({48{1'b1}} << rsh_s2_ff));
      end else begin
         q       = prod_s2_ff << lsh_s2_ff;
         rsticky = 1'b0;
      end
      rnd   = q[47:24];
      grd   = q[23];
      stk   = (|q[22:0]) | rsticky;
      inc   = grd & (stk | rnd[0]);
      total = {1'b0, ebase_s2_ff, 23'd0} + {9'd0, rnd} + {32'd0, inc};
      if (nan_s2_ff) begin
         y_in = F32_QNAN;
      end else if (inf_s2_ff) begin
         y_in = {sign_s2_ff, 8'hFF, 23'd0};
      end else if (zero_s2_ff) begin
         y_in = {sign_s2_ff, 31'd0};
      end else if (total[32:23] >= 10'd255) begin
         y_in = {sign_s2_ff, 8'hFF, 23'd0};
      end else begin
         y_in = {sign_s2_ff, total[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

@@ hdl/tnfs_fadd.sv @@
// Pipelined binary32 adder, round to nearest even, subnormals kept
module tnfs_fadd (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import tnfs_pkg::*;

   // stage 1: order by magnitude, exponent difference
   logic        swap, a_nan, b_nan, a_inf, b_inf;
   logic [31:0] big, sml;
   logic [7:0]  eb_eff, es_eff;

   logic        sign_s1_ff, sub_s1_ff, nan_s1_ff, inf_s1_ff, isign_s1_ff;
   logic [7:0]  ebig_s1_ff, dist_s1_ff;
   logic [23:0] sbig_s1_ff, ssml_s1_ff;

   always_comb begin
      swap   = (b[30:0] > a[30:0]);
      big    = swap ? b : a;
      sml    = swap ? a : b;
      eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sign_s1_ff  <= big[31];
         sub_s1_ff   <= a[31] ^ b[31];
         nan_s1_ff   <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
         inf_s1_ff   <= a_inf || b_inf;
         isign_s1_ff <= a_inf ? a[31] : b[31];
         ebig_s1_ff  <= eb_eff;
         dist_s1_ff  <= eb_eff - es_eff;
         sbig_s1_ff  <= {(big[30:23] != 8'd0), big[22:0]};
         ssml_s1_ff  <= {(sml[30:23] != 8'd0), sml[22:0]};
      end
   end

   // stage 2: align the smaller operand, add or subtract
   logic [26:0] sml_ext, al;
   logic        st;
   logic [27:0] big_ext, sum_in;

   logic        sign_s2_ff, sub_s2_ff, nan_s2_ff, inf_s2_ff, isign_s2_ff;
   logic [7:0]  ebig_s2_ff;
   logic [27:0] sum_s2_ff;

   always_comb begin
      sml_ext = {ssml_s1_ff, 3'b000};
      if (dist_s1_ff >= 8'd27) begin
         al = 27'd0;
         st = |ssml_s1_ff;
      end else begin
         al = sml_ext >> dist_s1_ff;
         st = |(sml_ext & ~({27{1'b1}} << dist_s1_ff));
      end
      al[0]   = al[0] | st;
      big_ext = {1'b0, sbig_s1_ff, 3'b000};
      sum_in  = sub_s1_ff ? (big_ext - {1'b0, al}) : (big_ext + {1'b0, al});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sign_s2_ff  <= sign_s1_ff;
         sub_s2_ff   <= sub_s1_ff;
         nan_s2_ff   <= nan_s1_ff;
         inf_s2_ff   <= inf_s1_ff;
         isign_s2_ff <= isign_s1_ff;
         ebig_s2_ff  <= ebig_s1_ff;
         sum_s2_ff   <= sum_in;
      end
   end

   // stage 3: normalize, round, pack
   logic [4:0]        lz;
   logic signed [9:0] exp_e;
   logic [27:0]       n;
   logic              extra, grd, stk, inc;
   logic [8:0]        ebase;
   logic [7:0]        sub_sh;
   logic [23:0]       rnd;
   logic [32:0]       total;
   logic [31:0]       y_in;
   logic [31:0]       y_ff;

   always_comb begin
      lz = 5'd28;
      for (int i = 0; i < 28; i++) begin
         if (sum_s2_ff[i]) lz = 5'(27 - i);
      end
      exp_e  = $signed({2'b00, ebig_s2_ff}) + 10'sd1 - $signed({5'b0, lz});
      sub_sh = ebig_s2_ff - 8'd1;
      extra  = 1'b0;
      if (lz == 5'd0) begin
         n     = sum_s2_ff >> 1;
         extra = sum_s2_ff[0];
         ebase = 9'(exp_e - 10'sd1);
      end else if (exp_e > 10'sd0) begin
         n     = sum_s2_ff << (lz - 5'd1);
         ebase = 9'(exp_e - 10'sd1);
      end else begin
         n     = sum_s2_ff << sub_sh[4:0];
         ebase = 9'd0;
      end
      rnd   = n[26:3];
      grd   = n[2];
      stk   = (|n[1:0]) | extra;
      inc   = grd & (stk | rnd[0]);
      total = {1'b0, ebase, 23'd0} + {9'd0, rnd} + {32'd0, inc};
      if (nan_s2_ff) begin
         y_in = F32_QNAN;
      end else if (inf_s2_ff) begin
         y_in = {isign_s2_ff, 8'hFF, 23'd0};
      end else if (sum_s2_ff == 28'd0) begin
         y_in = {(sign_s2_ff & !sub_s2_ff), 31'd0};
      end else if (total[32:23] >= 10'd255) begin
         y_in = {sign_s2_ff, 8'hFF, 23'd0};
      end else begin
         y_in = {sign_s2_ff, total[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

@@ hdl/tnfs_front.sv @@
// Front end: accept samples, classify them and look up the seed tables
module tnfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_sample_bits,
   input  logic               req_last_sample,
   input  logic               push_ready,
   output logic               push_valid,
   output tnfs_pkg::item_type push_item
);
   import tnfs_pkg::*;

   localparam int  EI_W      = $clog2(EXP_TABLE_DEPTH);
   localparam int  MI_W      = $clog2(MANT_TABLE_DEPTH);
   localparam real MANT_STEP = 1.0 / real'(MANT_TABLE_DEPTH);

   typedef word_type exp_rom_type  [EXP_TABLE_DEPTH];
   typedef word_type mant_rom_type [MANT_TABLE_DEPTH];

   // 1/sqrt(x) for x in [1, 2] by Newton steps without division
   function automatic real rsqrt_real(input real x);
      real yv;
      yv = 0.75;
      for (int k = 0; k < 40; k++) begin
         yv = yv * (1.5 - 0.5 * x * yv * yv);
      end
      return yv;
   endfunction

   // round v in [0.5, 1] to binary32, nearest even
   function automatic word_type to_f32_unit(input real v);
      real m;
      real fr;
      int  nv;
      if (v >= 1.0) return 32'h3F80_0000;
      m  = v * 16777216.0;
      nv = $rtoi(m);
      fr = m - real'(nv);
      if ((fr > 0.5) || ((fr == 0.5) && (nv % 2 == 1))) nv = nv + 1;
      if (nv >= 16777216) return 32'h3F80_0000;
      return {1'b0, 8'd126, nv[22:0]};
   endfunction

   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      word_type    r2;
      int          kk;
      int          h;
      r2 = to_f32_unit(rsqrt_real(2.0));
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         kk = k;
         if (kk == 0) kk = 1;
         else if (kk == EXP_TABLE_DEPTH - 1) kk = EXP_TABLE_DEPTH - 2;
         if (kk % 2 == 1) begin
            h      = (127 - kk) / 2;
            rom[k] = {1'b0, 8'(h + 127), 23'd0};
         end else begin
            h      = (128 - kk) / 2;
            rom[k] = {1'b0, 8'(h + 126), r2[22:0]};
         end
      end
      return rom;
   endfunction

   function automatic mant_rom_type build_mant_rom();
      mant_rom_type rom;
      for (int i = 0; i < MANT_TABLE_DEPTH; i++) begin
         rom[i] = to_f32_unit(rsqrt_real(1.0 + real'(i) * MANT_STEP));
      end
      return rom;
   endfunction

   localparam exp_rom_type  EXP_ROM  = build_exp_rom();
   localparam mant_rom_type MANT_ROM = build_mant_rom();

   logic     take, neg;
   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_stall = valid_ff && !push_ready;
   assign take      = req_valid && !req_stall;

   // below zero: sign set, not a zero, not a NaN
   assign neg = req_sample_bits[31] && (req_sample_bits[30:0] != 31'd0)
                && !((req_sample_bits[30:23] == 8'hFF) && (req_sample_bits[22:0] != 23'd0));

   assign valid_in = take || (valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.sample     <= req_sample_bits;
         item_ff.exp_scale  <= EXP_ROM[req_sample_bits[30 -: EI_W]];
         item_ff.mant_scale <= MANT_ROM[req_sample_bits[22 -: MI_W]];
         item_ff.neg        <= neg;
         item_ff.last       <= req_last_sample;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

@@ hdl/tnfs_back.sv @@
// Back end: Newton refinement pipeline on the seeded samples
module tnfs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  tnfs_pkg::item_type   in_item,
   output logic                 out_valid,
   output tnfs_pkg::result_type out_result
);
   import tnfs_pkg::*;

   localparam int T_LAT = 5 * FMUL_LAT + FADD_LAT;   // mul, mul, mul, mul, add, mul
   localparam int F_LAT = 3 * FMUL_LAT;              // sample needed at the fourth multiply
   localparam int C_LAT = 2 * FMUL_LAT + FADD_LAT;   // f*g waits for the subtract

   logic [31:0] g, p1, c, p2, t, u, r, t_neg;

   logic [31:0] f_line_ff [F_LAT];
   logic [31:0] g_line_ff [FMUL_LAT];
   logic [31:0] c_line_ff [C_LAT];
   logic        v_line_ff [T_LAT];
   logic        n_line_ff [T_LAT];
   logic        l_line_ff [T_LAT];

   // g = exponent seed * mantissa seed
   tnfs_fmul u_mul_seed (
      .clock(clock), .enable(enable), .a(in_item.exp_scale), .b(in_item.mant_scale), .y(g)
   );
   // 0.5*g and f*g side by side
   tnfs_fmul u_mul_half (
      .clock(clock), .enable(enable), .a(F32_HALF), .b(g), .y(p1)
   );
   tnfs_fmul u_mul_fg (
      .clock(clock), .enable(enable), .a(f_line_ff[FMUL_LAT-1]), .b(g), .y(c)
   );
   tnfs_fmul u_mul_gg (
      .clock(clock), .enable(enable), .a(p1), .b(g_line_ff[FMUL_LAT-1]), .y(p2)
   );
   tnfs_fmul u_mul_f (
      .clock(clock), .enable(enable), .a(p2), .b(f_line_ff[F_LAT-1]), .y(t)
   );

   assign t_neg = {~t[31], t[30:0]};

   tnfs_fadd u_sub (
      .clock(clock), .enable(enable), .a(F32_ONE_P5), .b(t_neg), .y(u)
   );
   tnfs_fmul u_mul_out (
      .clock(clock), .enable(enable), .a(c_line_ff[C_LAT-1]), .b(u), .y(r)
   );

   // advance the side lines with the arithmetic
   always_ff @(posedge clock) begin
      if (enable) begin
         f_line_ff[0] <= in_item.sample;
         for (int i = 1; i < F_LAT; i++) f_line_ff[i] <= f_line_ff[i-1];
         g_line_ff[0] <= g;
         for (int i = 1; i < FMUL_LAT; i++) g_line_ff[i] <= g_line_ff[i-1];
         c_line_ff[0] <= c;
         for (int i = 1; i < C_LAT; i++) c_line_ff[i] <= c_line_ff[i-1];
         n_line_ff[0] <= in_item.neg;
         l_line_ff[0] <= in_item.last;
         for (int i = 1; i < T_LAT; i++) begin
            n_line_ff[i] <= n_line_ff[i-1];
            l_line_ff[i] <= l_line_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < T_LAT; i++) v_line_ff[i] <= 1'b0;
      end else if (enable) begin
         v_line_ff[0] <= in_valid;
         for (int i = 1; i < T_LAT; i++) v_line_ff[i] <= v_line_ff[i-1];
      end
   end

   assign out_valid       = v_line_ff[T_LAT-1];
   assign out_result.root = n_line_ff[T_LAT-1] ? 32'd0 : r;
   assign out_result.done = l_line_ff[T_LAT-1];

endmodule

@@ hdl/table_newton_float_sqrt.sv @@
// Throughput: one sample per cycle unless the output stalls; every unit is fully pipelined.
// Path: 1 front register (table lookup), 1 queue slot, 18 back stages, 1 output register.
// Back stages: five 3-stage multipliers and one 3-stage adder on the Newton chain.
// Reset: synchronous; clears valid bits, queue pointers and count; tables are constant.
// A stalled result freezes the back pipeline; the 4-entry queue keeps the front accepting until full.
module table_newton_float_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_bits,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_root_bits,
   output logic        rsp_run_done
);
   import tnfs_pkg::*;
`include "table_newton_float_sqrt_defines.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // front to queue
   logic       push_valid, push_ready, push;
   item_type   push_item;

   // queue storage and bookkeeping
   item_type   q_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic       q_empty, pop;

   // back and output register
   logic       adv, back_valid;
   result_type back_result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   tnfs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_bits(req_sample_bits),
      .req_last_sample(req_last_sample),
      .push_ready     (push_ready),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   // Queue: take a classified transaction whenever a slot is free
   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_empty    = (count_ff == '0);
   assign push       = push_valid && push_ready;

   // The whole back end advances unless a finished result is held
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && !q_empty;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wr_ptr_ff] <= push_item;
   end

   tnfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (!q_empty),
      .in_item   (q_mem_ff[rd_ptr_ff]),
      .out_valid (back_valid),
      .out_result(back_result)
   );

   // Output register: hold while stalled, load the back end's last stage otherwise
   assign rsp_valid_in = adv ? back_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= back_result;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root_bits = rsp_ff.root;
   assign rsp_run_done  = rsp_ff.done;

   `TNFS_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `TNFS_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall, !push_ready && push_valid, "front stalled with queue room")
   `TNFS_ASSERT_NEXT(a_no_pop_on_hold, clock, reset, rsp_valid_ff && rsp_stall, count_ff >= $past(count_ff), "queue drained while output held")

endmodule

@@ tb/tb_table_newton_float_sqrt.sv @@
// Self-checking testbench for the table-seeded Newton square root block
module tb_table_newton_float_sqrt;
   import tnfs_pkg::*;

   localparam int CLK_HIGH     = 4;
   localparam int CLK_LOW      = 4;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1100;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_sample_bits;
   logic        req_last_sample;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_root_bits;
   logic        rsp_run_done;

   int          mismatch_count;
   int          cycle_count;

   word_type    exp_scale_rom  [EXP_TABLE_DEPTH];
   word_type    mant_scale_rom [MANT_TABLE_DEPTH];

   table_newton_float_sqrt DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_bits (req_sample_bits),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_root_bits   (rsp_root_bits),
      .rsp_run_done    (rsp_run_done)
   );

   always begin
      clock = 1'b1;
      #CLK_HIGH;
      clock = 1'b0;
      #CLK_LOW;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Widen a binary32 pattern to a double; exact for every class, denormals too
   function automatic real widen_f32(input word_type w);
      logic [10:0] dexp;
      real         mag;
      if (w[30:23] == 8'hFF) begin
         return $bitstoreal({w[31], 11'h7FF, w[22:0], 29'b0});
      end
      if (w[30:23] == 8'h00) begin
         mag = real'(w[22:0]) * (2.0 ** (-149.0));
         return w[31] ? -mag : mag;
      end
      dexp = 11'(w[30:23]) + 11'd896;
      return $bitstoreal({w[31], dexp, w[22:0], 29'b0});
   endfunction

   // Round a double to binary32, nearest-even, with gradual underflow
   function automatic word_type round_f32(input real d);
      logic [63:0] db;
      logic [63:0] sig;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      logic [31:0] mag;
      int          uexp;
      int          shift;
      db = $realtobits(d);
      if (db[62:52] == 11'h7FF) begin
         return (db[51:0] != 0) ? F32_QNAN : {db[63], 8'hFF, 23'b0};
      end
      if (db[62:52] == 11'h000) begin
         return {db[63], 31'b0};
      end
      uexp = int'(db[62:52]) - 1023;
      if (uexp > 127) begin
         return {db[63], 8'hFF, 23'b0};
      end
      sig = {11'b0, 1'b1, db[51:0]};
      shift = (uexp >= -126) ? 29 : 29 + (-126 - uexp);
      if (shift > 60) begin
         return {db[63], 31'b0};
      end
      kept = sig >> shift;
      rem  = sig & ((64'd1 << shift) - 64'd1);
      half = 64'd1 << (shift - 1);
      if (uexp >= -126) begin
         mag = 32'(((uexp + 127) << 23)) | 32'(kept & 64'h7F_FFFF);
      end else begin
         mag = 32'(kept);
      end
      // carry out of the fraction lands in the exponent, up to infinity
      if (rem > half || (rem == half && kept[0])) begin
         mag = mag + 32'd1;
      end
      return {db[63], mag[30:0]};
   endfunction

   function automatic word_type mul_f32(input word_type a, input word_type b);
      return round_f32(widen_f32(a) * widen_f32(b));
   endfunction

   function automatic real root_newton(input real x);
      real s;
      s = 1.5;
      for (int k = 0; k < 12; k++) begin
         s = 0.5 * (s + x / s);
      end
      return s;
   endfunction

   task automatic fill_scale_roms();
      word_type inv_root2;
      int       kk;
      int       h;
      inv_root2 = round_f32(1.0 / root_newton(2.0));
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         kk = (k == 0) ? 1 : (k == EXP_TABLE_DEPTH - 1) ? EXP_TABLE_DEPTH - 2 : k;
         if (kk % 2 == 1) begin
            h = (127 - kk) / 2;
            exp_scale_rom[k] = 32'((h + 127) << 23);
         end else begin
            h = (128 - kk) / 2;
            exp_scale_rom[k] = mul_f32(inv_root2, 32'((h + 127) << 23));
         end
      end
      for (int i = 0; i < MANT_TABLE_DEPTH; i++) begin
         mant_scale_rom[i] =
            round_f32(1.0 / root_newton(1.0 + real'(i) / real'(MANT_TABLE_DEPTH)));
      end
   endtask

   function automatic word_type predict_root(input word_type sample);
      word_type g;
      word_type t;
      word_type u;
      word_type r;
      // below zero: sign set, nonzero magnitude, not a NaN
      if (sample[31] && sample[30:0] != 0 &&
          !(sample[30:23] == 8'hFF && sample[22:0] != 0)) begin
         return 32'h0;
      end
      g = mul_f32(exp_scale_rom[sample[30:23]], mant_scale_rom[sample[22:13]]);
      t = mul_f32(mul_f32(mul_f32(F32_HALF, g), g), sample);
      u = round_f32(widen_f32(F32_ONE_P5) - widen_f32(t));
      r = mul_f32(mul_f32(sample, g), u);
      if (r[30:23] == 8'hFF && r[22:0] != 0) begin
         r = F32_QNAN;
      end
      return r;
   endfunction

   class root_scoreboard;
      result_type expected_roots[$];

      function void note_input(input word_type sample, input logic last);
         result_type e;
         e.root = predict_root(sample);
         e.done = last;
         expected_roots.push_back(e);
      endfunction

      task check_result(input word_type root, input logic done);
         result_type e;
         if (expected_roots.size() == 0) begin
            report_mismatch($sformatf("unexpected result root=%h done=%b", root, done));
         end else begin
            e = expected_roots.pop_front();
            if (root !== e.root)
               report_mismatch($sformatf("root got %h want %h", root, e.root));
            if (done !== e.done)
               report_mismatch($sformatf("run_done got %b want %b", done, e.done));
         end
      endtask

      function int pending();
         return expected_roots.size();
      endfunction
   endclass

   root_scoreboard roots_sb = new();

   // Mostly short gaps, a few long ones; burst phases force zero
   function automatic int pick_gap(input bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drive one transaction; valid stays high into the next call when there is no gap
   task automatic send_sample(input word_type bits, input logic last, input bit burst);
      int gap;
      gap = pick_gap(burst);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_sample_bits = bits;
      req_last_sample = last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic word_type random_sample();
      int       r;
      word_type w;
      r = $urandom_range(0, 99);
      w = $urandom();
      if (r < 55) begin
         // positive normal, moderate exponent range
         w[31]    = 1'b0;
         w[30:23] = 8'($urandom_range(64, 190));
      end else if (r < 65) begin
         w[31]    = 1'b0;
         w[30:23] = 8'($urandom_range(1, 254));
      end else if (r < 75) begin
         w[30:23] = 8'h00;
      end else if (r < 82) begin
         w[30:23] = 8'hFF;
         if ($urandom_range(0, 1)) w[22:0] = 0;
      end
      return w;
   endfunction

   // Accept monitor: note every input transaction at the edge it is taken
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         roots_sb.note_input(req_sample_bits, req_last_sample);
   end

   // Result monitor: compare every output transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         roots_sb.check_result(rsp_root_bits, rsp_run_done);
   end

   // Watchdog: bound the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("table_newton_float_sqrt verification failed");
         $finish;
      end
   end

   // Receiver: random stalls, bursts with none, and one long hold-off
   initial begin
      int  r;
      int  left;
      bit  burst;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      for (int c = 0; ; c++) begin
         if (c == 400) begin
            // hold off long enough for the queue and pipeline to fill and stall input
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         burst = ((c / 150) % 4) == 2;
         r = $urandom_range(0, 99);
         if (burst || r < 65) left = 0;
         else if (r < 93) left = $urandom_range(1, 3);
         else left = $urandom_range(10, 40);
         if (left > 0) begin
            rsp_stall = 1'b1;
            repeat (left) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(negedge clock);
      end
   end

   // Stimulus and end of run
   initial begin
      word_type directed[$];
      int       wait_cycles;
      mismatch_count  = 0;
      cycle_count     = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample_bits = '0;
      req_last_sample = 1'b0;
      fill_scale_roms();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zeros, infinities, NaNs, denormals, extremes, negatives
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'hFFC0_0001,
                   32'h0000_0001, 32'h007F_FFFF, 32'h8000_0001, 32'h0080_0000,
                   32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000, 32'h4000_0000,
                   32'h4080_0000, 32'h3FFF_E000, 32'h4B00_0000, 32'hBF80_0000,
                   32'h0000_2000, 32'h7FFF_FFFF, 32'h5555_5555, 32'h2AAA_AAAA};
      foreach (directed[i])
         send_sample(directed[i], 1'(i == directed.size() - 1), 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_sample(random_sample(), 1'($urandom_range(0, 7) == 0), ((n / 100) % 3) == 1);
      req_valid = 1'b0;

      wait_cycles = 0;
      while (roots_sb.pending() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (roots_sb.pending() != 0)
         report_mismatch($sformatf("%0d results never arrived", roots_sb.pending()));

      if (mismatch_count == 0) begin
         $display("table_newton_float_sqrt verification clean");
      end else begin
         $display("table_newton_float_sqrt verification failed");
      end
      $finish;
   end

endmodule
